>>> rtl/rvis_pkg.sv
`default_nettype none
package rvis_pkg;

    // machine dimensions
    localparam int REG_COUNT     = 16;
    localparam int MEM_BYTES     = 4096;
    localparam int PROGRAM_DEPTH = 4096;
    localparam int REG_AW        = $clog2(REG_COUNT);
    localparam int MEM_AW        = $clog2(MEM_BYTES);
    localparam int IDX_W         = 12;
    localparam int PLEN_W        = 13;

    // opcodes
    localparam logic [4:0] OP_NOP       = 5'd0;
    localparam logic [4:0] OP_HALT      = 5'd1;
    localparam logic [4:0] OP_LOADCONST = 5'd2;
    localparam logic [4:0] OP_LOADMASK  = 5'd3;
    localparam logic [4:0] OP_LOADIND   = 5'd4;
    localparam logic [4:0] OP_PUSH      = 5'd5;
    localparam logic [4:0] OP_POP       = 5'd6;
    localparam logic [4:0] OP_STOREIND  = 5'd7;
    localparam logic [4:0] OP_JMP       = 5'd8;
    localparam logic [4:0] OP_JFALSE    = 5'd9;
    localparam logic [4:0] OP_JTRUE     = 5'd10;
    localparam logic [4:0] OP_ADD       = 5'd11;
    localparam logic [4:0] OP_SUB       = 5'd12;
    localparam logic [4:0] OP_MUL       = 5'd13;
    localparam logic [4:0] OP_DIV       = 5'd14;
    localparam logic [4:0] OP_MOD       = 5'd15;
    localparam logic [4:0] OP_CALL      = 5'd16;
    localparam logic [4:0] OP_RET       = 5'd17;
    localparam logic [4:0] OP_SYSCALL   = 5'd18;

    // result status codes
    localparam logic [2:0] ST_CONT    = 3'd0;
    localparam logic [2:0] ST_HALT    = 3'd1;
    localparam logic [2:0] ST_BADOP   = 3'd2;
    localparam logic [2:0] ST_SYSCALL = 3'd3;
    localparam logic [2:0] ST_MEMF    = 3'd4;
    localparam logic [2:0] ST_REGF    = 3'd5;
    localparam logic [2:0] ST_DIVZ    = 3'd6;
    localparam logic [2:0] ST_BADIDX  = 3'd7;

    // register read operand select
    localparam logic [1:0] RS_A1 = 2'd0;
    localparam logic [1:0] RS_A2 = 2'd1;
    localparam logic [1:0] RS_A3 = 2'd2;
    localparam logic [1:0] RS_SP = 2'd3;

    typedef struct packed {
        logic       latch;
        logic       rd_issue;
        logic [1:0] rd_sel;
        logic       cap_a;
        logic       cap_b;
        logic       addr_calc;
        logic       iter_init;
        logic       iter_step;
        logic       ld_clear;
        logic       ld_issue;
        logic       ld_cap;
        logic       st_write;
        logic [2:0] byte_idx;
        logic       val_calc;
        logic       rf_wr_dst;
        logic       rf_wr_sp;
        logic       idx_commit;
        logic       out_load;
        logic [2:0] out_status;
        logic       out_sys;
    } rvis_cmd_t;

    typedef struct packed {
        logic [4:0] opcode;
        logic       idx_bad;
        logic       reg_fault;
        logic       cnt_big;
        logic       mem_fault;
        logic       div_zero;
        logic       next_bad;
        logic [3:0] mem_len;
    } rvis_stat_t;

endpackage
`default_nettype wire

>>> rtl/register_vm_instruction_step_core.sv
`default_nettype none
// channel  | direction | words carried
// s_       | in        | opcode, first_arg, second_arg, third_arg
// m_       | out       | status, next_index, syscall_number
// cfg_     | in        | program_length (13 bits)
//
// a word stops at decode on halt, stopped machine, bad index, bad opcode or
// register fault; mul, div and mod run through the one-bit-per-cycle
// multiply/divide unit, and memory goes through the single-byte data memory
// port (loads issue and then capture each byte, stores write one byte per
// cycle); a new result waits while m_ready holds off the one before it.
// aresetn is synchronous; it clears index, stop flag and register valid bits.
// a waiting result sits in the output register while the next word runs.
module register_vm_instruction_step_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [4:0]  s_opcode,
    input  wire logic [63:0] s_first_arg,
    input  wire logic [63:0] s_second_arg,
    input  wire logic [7:0]  s_third_arg,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [2:0]       m_status,
    output logic [11:0]      m_next_index,
    output logic [63:0]      m_syscall_number,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [12:0] cfg_data
);

    rvis_pkg::rvis_cmd_t  cmd;
    rvis_pkg::rvis_stat_t stat;

    // config always taken
    assign cfg_ready = 1'b1;

    rvis_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    rvis_dp u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .stat             (stat),
        .s_opcode         (s_opcode),
        .s_first_arg      (s_first_arg),
        .s_second_arg     (s_second_arg),
        .s_third_arg      (s_third_arg),
        .cfg_valid        (cfg_valid),
        .cfg_data         (cfg_data),
        .m_status         (m_status),
        .m_next_index     (m_next_index),
        .m_syscall_number (m_syscall_number)
    );

endmodule
`default_nettype wire

>>> rtl/rvis_dp.sv
`default_nettype none
module rvis_dp (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire rvis_pkg::rvis_cmd_t cmd,
    output rvis_pkg::rvis_stat_t    stat,
    input  wire logic [4:0]         s_opcode,
    input  wire logic [63:0]        s_first_arg,
    input  wire logic [63:0]        s_second_arg,
    input  wire logic [7:0]         s_third_arg,
    input  wire logic               cfg_valid,
    input  wire logic [12:0]        cfg_data,
    output logic [2:0]              m_status,
    output logic [11:0]             m_next_index,
    output logic [63:0]             m_syscall_number
);

    logic [4:0]  op_reg;
    logic [63:0] a1_reg, a2_reg;
    logic [7:0]  a3_reg;
    logic [rvis_pkg::PLEN_W-1:0] plen_reg;
    logic [rvis_pkg::IDX_W-1:0]  idx_reg;
    logic [63:0] rd_data_reg, opa_reg, opb_reg;
    logic [63:0] maddr_reg;
    logic [64:0] acc_reg;
    logic [63:0] itq_reg, itm_reg;
    logic [63:0] ld_reg, val_reg, next_reg, sp_new_reg;
    logic [2:0]  st_reg;
    logic [11:0] ni_reg;
    logic [63:0] sys_reg;

    logic [63:0] rf_mem [rvis_pkg::REG_COUNT];
    logic [rvis_pkg::REG_COUNT-1:0] rf_vld_reg;
    logic [7:0]  dm_mem [rvis_pkg::MEM_BYTES];
    logic [7:0]  dm_rdata_reg;

    logic ok1, ok2, ok3;
    logic [rvis_pkg::REG_AW-1:0] raddr, waddr;
    logic [63:0] wdata;
    logic        rf_we;
    logic [rvis_pkg::MEM_AW-1:0] dm_addr;
    logic [63:0] seq_next, st_val;
    logic [64:0] div_t;
    logic [63:0] mlen64;

    function automatic logic mem_ok(input logic [63:0] addr, input logic [63:0] n);
        mem_ok = (addr <= 64'(rvis_pkg::MEM_BYTES)) &&
                 (n <= 64'(rvis_pkg::MEM_BYTES) - addr);
    endfunction

    function automatic logic [63:0] byte_mask(input logic [7:0] n);
        logic [63:0] m;
        m = '1;
        if (n < 8'd8) m = (64'd1 << {n[2:0], 3'b000}) - 64'd1;
        byte_mask = m;
    endfunction

    // instruction capture and config
    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            op_reg <= s_opcode;
            a1_reg <= s_first_arg;
            a2_reg <= s_second_arg;
            a3_reg <= s_third_arg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            plen_reg <= '0;
            idx_reg  <= '0;
        end else begin
            if (cfg_valid) plen_reg <= cfg_data;
            if (cmd.idx_commit) idx_reg <= next_reg[rvis_pkg::IDX_W-1:0];
        end
    end

    // operand range checks
    assign ok1 = a1_reg < 64'(rvis_pkg::REG_COUNT);
    assign ok2 = a2_reg < 64'(rvis_pkg::REG_COUNT);
    assign ok3 = {56'd0, a3_reg} < 64'(rvis_pkg::REG_COUNT);

    always_comb begin
        stat.reg_fault = 1'b0;
        case (op_reg)
            rvis_pkg::OP_LOADCONST, rvis_pkg::OP_PUSH, rvis_pkg::OP_POP,
            rvis_pkg::OP_JFALSE, rvis_pkg::OP_JTRUE: stat.reg_fault = !ok1;
            rvis_pkg::OP_LOADMASK, rvis_pkg::OP_LOADIND,
            rvis_pkg::OP_STOREIND: stat.reg_fault = !ok1 || !ok2;
            rvis_pkg::OP_ADD, rvis_pkg::OP_SUB, rvis_pkg::OP_MUL,
            rvis_pkg::OP_DIV, rvis_pkg::OP_MOD: stat.reg_fault = !ok1 || !ok2 || !ok3;
            default: stat.reg_fault = 1'b0;
        endcase
    end

    assign stat.opcode  = op_reg;
    assign stat.cnt_big = a3_reg > 8'd8;
    assign stat.idx_bad = ({1'b0, idx_reg} >= plen_reg) ||
                          (32'(idx_reg) >= 32'(rvis_pkg::PROGRAM_DEPTH));
    assign stat.div_zero = opb_reg == 64'd0;
    assign stat.next_bad = (next_reg >= 64'(plen_reg)) ||
                           (next_reg >= 64'(rvis_pkg::PROGRAM_DEPTH));

    // access length, 8 for stack traffic
    always_comb begin
        stat.mem_len = 4'd8;
        if (op_reg == rvis_pkg::OP_LOADIND || op_reg == rvis_pkg::OP_STOREIND)
            stat.mem_len = a3_reg[3:0];
    end
    assign mlen64 = (op_reg == rvis_pkg::OP_LOADIND || op_reg == rvis_pkg::OP_STOREIND) ?
                    {56'd0, a3_reg} : 64'd8;

    always_comb begin
        stat.mem_fault = !mem_ok(maddr_reg, mlen64);
        case (op_reg)
            rvis_pkg::OP_LOADIND, rvis_pkg::OP_STOREIND:
                stat.mem_fault = (a3_reg > 8'd8) || !mem_ok(maddr_reg, mlen64);
            rvis_pkg::OP_PUSH, rvis_pkg::OP_CALL:
                stat.mem_fault = (opa_reg < 64'd8) || !mem_ok(maddr_reg, mlen64);
            default: stat.mem_fault = !mem_ok(maddr_reg, mlen64);
        endcase
    end

    // register file read port
    always_comb begin
        case (cmd.rd_sel)
            rvis_pkg::RS_A1: raddr = a1_reg[rvis_pkg::REG_AW-1:0];
            rvis_pkg::RS_A2: raddr = a2_reg[rvis_pkg::REG_AW-1:0];
            rvis_pkg::RS_A3: raddr = a3_reg[rvis_pkg::REG_AW-1:0];
            default:         raddr = rvis_pkg::REG_AW'(1);
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.rd_issue) begin
            if (raddr == '0)
                rd_data_reg <= 64'(idx_reg);
            else if (rf_vld_reg[raddr])
                rd_data_reg <= rf_mem[raddr];
            else if (raddr == rvis_pkg::REG_AW'(1))
                rd_data_reg <= 64'(rvis_pkg::MEM_BYTES);
            else
                rd_data_reg <= 64'd0;
        end
    end

    // register file write port
    assign rf_we = (cmd.rf_wr_dst && a1_reg[rvis_pkg::REG_AW-1:0] != '0) || cmd.rf_wr_sp;
    assign waddr = cmd.rf_wr_sp ? rvis_pkg::REG_AW'(1) : a1_reg[rvis_pkg::REG_AW-1:0];
    assign wdata = cmd.rf_wr_sp ? sp_new_reg : val_reg;

    always_ff @(posedge aclk) begin
        if (rf_we) rf_mem[waddr] <= wdata;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) rf_vld_reg <= '0;
        else if (rf_we) rf_vld_reg[waddr] <= 1'b1;
    end

    // operands and access address
    always_ff @(posedge aclk) begin
        if (cmd.cap_a) opa_reg <= rd_data_reg;
        if (cmd.cap_b) opb_reg <= rd_data_reg;
        if (cmd.addr_calc) begin
            if (op_reg == rvis_pkg::OP_PUSH || op_reg == rvis_pkg::OP_CALL)
                maddr_reg <= opa_reg - 64'd8;
            else
                maddr_reg <= opa_reg;
        end
    end

    // shift-add multiply, restoring divide
    assign div_t = {acc_reg[63:0], itq_reg[63]};
    always_ff @(posedge aclk) begin
        if (cmd.iter_init) begin
            acc_reg <= '0;
            itq_reg <= (op_reg == rvis_pkg::OP_MUL) ? opb_reg : opa_reg;
            itm_reg <= opa_reg;
        end else if (cmd.iter_step) begin
            if (op_reg == rvis_pkg::OP_MUL) begin
                if (itq_reg[0]) acc_reg <= {1'b0, acc_reg[63:0] + itm_reg};
                itm_reg <= {itm_reg[62:0], 1'b0};
                itq_reg <= {1'b0, itq_reg[63:1]};
            end else begin
                if (div_t >= {1'b0, opb_reg}) begin
                    acc_reg <= div_t - {1'b0, opb_reg};
                    itq_reg <= {itq_reg[62:0], 1'b1};
                end else begin
                    acc_reg <= div_t;
                    itq_reg <= {itq_reg[62:0], 1'b0};
                end
            end
        end
    end

    // data memory, one byte per access; stores write one byte per cycle
    assign dm_addr = maddr_reg[rvis_pkg::MEM_AW-1:0] + rvis_pkg::MEM_AW'(cmd.byte_idx);
    assign seq_next = 64'(idx_reg) + 64'd1;
    assign st_val = (op_reg == rvis_pkg::OP_CALL) ? seq_next : opb_reg;

    always_ff @(posedge aclk) begin
        if (cmd.st_write) dm_mem[dm_addr] <= st_val[{cmd.byte_idx, 3'b000} +: 8];
        if (cmd.ld_issue) dm_rdata_reg <= dm_mem[dm_addr];
    end

    always_ff @(posedge aclk) begin
        if (cmd.ld_clear) ld_reg <= '0;
        else if (cmd.ld_cap) ld_reg[{cmd.byte_idx, 3'b000} +: 8] <= dm_rdata_reg;
    end

    // result value, next index and moved stack pointer
    always_ff @(posedge aclk) begin
        if (cmd.val_calc) begin
            case (op_reg)
                rvis_pkg::OP_LOADCONST: val_reg <= a2_reg;
                rvis_pkg::OP_LOADMASK:  val_reg <= opa_reg & byte_mask(a3_reg);
                rvis_pkg::OP_ADD:       val_reg <= opa_reg + opb_reg;
                rvis_pkg::OP_SUB:       val_reg <= opa_reg - opb_reg;
                rvis_pkg::OP_MUL:       val_reg <= acc_reg[63:0];
                rvis_pkg::OP_DIV:       val_reg <= itq_reg;
                rvis_pkg::OP_MOD:       val_reg <= acc_reg[63:0];
                default:                val_reg <= ld_reg;
            endcase
            case (op_reg)
                rvis_pkg::OP_JMP, rvis_pkg::OP_CALL: next_reg <= a1_reg;
                rvis_pkg::OP_JFALSE: next_reg <= (opa_reg == 64'd0) ? a2_reg : seq_next;
                rvis_pkg::OP_JTRUE:  next_reg <= (opa_reg != 64'd0) ? a2_reg : seq_next;
                rvis_pkg::OP_RET:    next_reg <= ld_reg;
                default:             next_reg <= seq_next;
            endcase
            if (op_reg == rvis_pkg::OP_PUSH || op_reg == rvis_pkg::OP_CALL)
                sp_new_reg <= maddr_reg;
            else
                sp_new_reg <= opa_reg + 64'd8;
        end
    end

    // result word register
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            st_reg  <= cmd.out_status;
            ni_reg  <= 12'(idx_reg);
            sys_reg <= cmd.out_sys ? a1_reg : 64'd0;
        end
    end

    assign m_status         = st_reg;
    assign m_next_index     = ni_reg;
    assign m_syscall_number = sys_reg;

endmodule
`default_nettype wire

>>> rtl/rvis_ctrl.sv
`default_nettype none
module rvis_ctrl (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    output logic                     m_valid,
    input  wire logic                m_ready,
    input  wire rvis_pkg::rvis_stat_t stat,
    output rvis_pkg::rvis_cmd_t      cmd
);

    typedef enum logic [3:0] {
        S_IDLE, S_DEC, S_RD1, S_RD2, S_RD3, S_ADDR, S_CHK, S_ITER,
        S_LDI, S_LDC, S_NEXT, S_NCHK, S_ST, S_WB, S_SP, S_OUT
    } state_t;

    state_t     state_reg, state_next;
    logic [6:0] cnt_reg, cnt_next;
    logic       stopped_reg, stopped_next;
    logic       m_valid_reg, m_valid_next;
    logic [2:0] pend_reg, pend_next;
    logic       psys_reg, psys_next;

    logic is_stack, is_two, is_memop, is_load, is_store, is_wr, is_iter, is_divop;
    logic [1:0] sel1, sel2;

    // opcode classes
    always_comb begin
        is_stack = 1'b0; is_two = 1'b0; is_memop = 1'b0; is_load = 1'b0;
        is_store = 1'b0; is_wr = 1'b0; is_iter = 1'b0; is_divop = 1'b0;
        sel1 = rvis_pkg::RS_A2; sel2 = rvis_pkg::RS_A3;
        case (stat.opcode)
            rvis_pkg::OP_LOADCONST: is_wr = 1'b1;
            rvis_pkg::OP_LOADMASK:  is_wr = 1'b1;
            rvis_pkg::OP_LOADIND: begin
                is_wr = 1'b1; is_memop = 1'b1; is_load = 1'b1;
            end
            rvis_pkg::OP_PUSH: begin
                is_stack = 1'b1; is_memop = 1'b1; is_store = 1'b1; is_two = 1'b1;
                sel1 = rvis_pkg::RS_SP; sel2 = rvis_pkg::RS_A1;
            end
            rvis_pkg::OP_CALL: begin
                is_stack = 1'b1; is_memop = 1'b1; is_store = 1'b1;
                sel1 = rvis_pkg::RS_SP;
            end
            rvis_pkg::OP_POP: begin
                is_stack = 1'b1; is_memop = 1'b1; is_load = 1'b1; is_wr = 1'b1;
                sel1 = rvis_pkg::RS_SP;
            end
            rvis_pkg::OP_RET: begin
                is_stack = 1'b1; is_memop = 1'b1; is_load = 1'b1;
                sel1 = rvis_pkg::RS_SP;
            end
            rvis_pkg::OP_STOREIND: begin
                is_memop = 1'b1; is_store = 1'b1; is_two = 1'b1;
                sel1 = rvis_pkg::RS_A1; sel2 = rvis_pkg::RS_A2;
            end
            rvis_pkg::OP_JFALSE, rvis_pkg::OP_JTRUE: sel1 = rvis_pkg::RS_A1;
            rvis_pkg::OP_ADD, rvis_pkg::OP_SUB: begin
                is_wr = 1'b1; is_two = 1'b1;
            end
            rvis_pkg::OP_MUL: begin
                is_wr = 1'b1; is_two = 1'b1; is_iter = 1'b1;
            end
            rvis_pkg::OP_DIV, rvis_pkg::OP_MOD: begin
                is_wr = 1'b1; is_two = 1'b1; is_iter = 1'b1; is_divop = 1'b1;
            end
            default: is_wr = 1'b0;
        endcase
    end

    // sequencing
    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        stopped_next = stopped_reg;
        pend_next    = pend_reg;
        psys_next    = psys_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd          = '0;
        cmd.byte_idx = cnt_reg[2:0];
        cmd.rd_sel   = sel1;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.latch  = 1'b1;
                    state_next = S_DEC;
                end
            end
            S_DEC: begin
                pend_next  = rvis_pkg::ST_CONT;
                psys_next  = 1'b0;
                state_next = S_OUT;
                if (stopped_reg) begin
                    pend_next = rvis_pkg::ST_HALT;
                end else if (stat.idx_bad) begin
                    pend_next = rvis_pkg::ST_BADIDX; stopped_next = 1'b1;
                end else if (stat.opcode == rvis_pkg::OP_HALT) begin
                    pend_next = rvis_pkg::ST_HALT; stopped_next = 1'b1;
                end else if (stat.opcode > rvis_pkg::OP_SYSCALL) begin
                    pend_next = rvis_pkg::ST_BADOP; stopped_next = 1'b1;
                end else if (stat.reg_fault) begin
                    pend_next = rvis_pkg::ST_REGF; stopped_next = 1'b1;
                end else if (stat.opcode == rvis_pkg::OP_LOADMASK && stat.cnt_big) begin
                    pend_next = rvis_pkg::ST_BADOP; stopped_next = 1'b1;
                end else begin
                    case (stat.opcode)
                        rvis_pkg::OP_NOP, rvis_pkg::OP_JMP, rvis_pkg::OP_LOADCONST:
                            state_next = S_NEXT;
                        rvis_pkg::OP_SYSCALL: begin
                            pend_next = rvis_pkg::ST_SYSCALL; psys_next = 1'b1;
                            state_next = S_NEXT;
                        end
                        default: state_next = S_RD1;
                    endcase
                end
            end
            S_RD1: begin
                cmd.rd_issue = 1'b1;
                state_next   = S_RD2;
            end
            S_RD2: begin
                cmd.cap_a = 1'b1;
                if (is_two) begin
                    cmd.rd_issue = 1'b1;
                    cmd.rd_sel   = sel2;
                    state_next   = S_RD3;
                end else begin
                    state_next = S_ADDR;
                end
            end
            S_RD3: begin
                cmd.cap_b  = 1'b1;
                state_next = S_ADDR;
            end
            S_ADDR: begin
                cmd.addr_calc = 1'b1;
                state_next    = S_CHK;
            end
            S_CHK: begin
                cnt_next = '0;
                if (is_memop && stat.mem_fault) begin
                    pend_next = rvis_pkg::ST_MEMF; stopped_next = 1'b1;
                    state_next = S_OUT;
                end else if (is_divop && stat.div_zero) begin
                    pend_next = rvis_pkg::ST_DIVZ; stopped_next = 1'b1;
                    state_next = S_OUT;
                end else if (is_iter) begin
                    cmd.iter_init = 1'b1;
                    state_next    = S_ITER;
                end else if (is_load) begin
                    cmd.ld_clear = 1'b1;
                    state_next   = S_LDI;
                end else begin
                    state_next = S_NEXT;
                end
            end
            S_ITER: begin
                cmd.iter_step = 1'b1;
                cnt_next      = cnt_reg + 7'd1;
                if (cnt_reg == 7'd63) state_next = S_NEXT;
            end
            S_LDI: begin
                if (cnt_reg == {3'd0, stat.mem_len}) begin
                    state_next = S_NEXT;
                end else begin
                    cmd.ld_issue = 1'b1;
                    state_next   = S_LDC;
                end
            end
            S_LDC: begin
                cmd.ld_cap = 1'b1;
                cnt_next   = cnt_reg + 7'd1;
                state_next = S_LDI;
            end
            S_NEXT: begin
                cmd.val_calc = 1'b1;
                state_next   = S_NCHK;
            end
            S_NCHK: begin
                cnt_next = '0;
                if (stat.next_bad) begin
                    pend_next = rvis_pkg::ST_BADIDX; psys_next = 1'b0;
                    stopped_next = 1'b1;
                    state_next = S_OUT;
                end else if (is_store) begin
                    state_next = S_ST;
                end else begin
                    state_next = S_WB;
                end
            end
            S_ST: begin
                if (cnt_reg == {3'd0, stat.mem_len}) begin
                    state_next = S_WB;
                end else begin
                    cmd.st_write = 1'b1;
                    cnt_next     = cnt_reg + 7'd1;
                end
            end
            S_WB: begin
                cmd.rf_wr_dst = is_wr;
                state_next    = S_SP;
            end
            S_SP: begin
                cmd.rf_wr_sp   = is_stack;
                cmd.idx_commit = 1'b1;
                state_next     = S_OUT;
            end
            S_OUT: begin
                cmd.out_status = pend_reg;
                cmd.out_sys    = psys_reg;
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            stopped_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            pend_reg    <= rvis_pkg::ST_CONT;
            psys_reg    <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            stopped_reg <= stopped_next;
            m_valid_reg <= m_valid_next;
            pend_reg    <= pend_next;
            psys_reg    <= psys_next;
        end
    end

    assign s_ready = state_reg == S_IDLE;
    assign m_valid = m_valid_reg;

endmodule
`default_nettype wire
